@@ src/inverse_variance_fusion_top_macros.svh @@
// ----------------------------------------------------------------------------
// Inverse variance fusion assertion macros
// Shared concurrent assertion forms for the checker of the fusion block.
// ----------------------------------------------------------------------------
`ifndef INVERSE_VARIANCE_FUSION_TOP_MACROS_SVH
`define INVERSE_VARIANCE_FUSION_TOP_MACROS_SVH

// Assertion sampled on the rising clock edge, disabled while reset is high.
`define IVF_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion sampled on the rising clock edge that also holds during reset.
`define IVF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/ivf_pkg.sv @@
// ----------------------------------------------------------------------------
// Inverse variance fusion package
// Fixed-point constants and shared types of the fusion block.
// ----------------------------------------------------------------------------
package ivf_pkg;

   // Fraction bits of the Q format used by means and deviations.
   localparam int FRAC_BITS = 16;
   // The weight numerator is 2^(2F+24), giving a Q40.24 weight.
   localparam int NUM_EXP = 2 * FRAC_BITS + 24;
   localparam logic [127:0] NUM_WIDE = 128'(1) << NUM_EXP;

   localparam int DIV_STEPS = 64;
   localparam int SQRT_STEPS = 32;

   // Register index decoded from byte address bit 2.
   localparam logic CSR_IDX_MIN_STD = 1'b0;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ src/ivf_div.sv @@
// ----------------------------------------------------------------------------
// Inverse variance fusion divider
// Restoring 128 by 64 bit divider, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module ivf_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [127:0]            num,
   input  logic [63:0]             den,
   output ivf_pkg::div_status_type status,
   output logic [63:0]             quo
);
   import ivf_pkg::*;

   localparam int CNT_W = $clog2(DIV_STEPS);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]      rem_ff, rem_in;
   logic [63:0]      quo_ff, quo_in;
   logic [63:0]      den_ff, den_in;
   logic [64:0]      rem_shift;
   logic [64:0]      rem_diff;
   logic             rem_ge;

   assign rem_shift = {rem_ff, quo_ff[63]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};
   assign rem_ge    = rem_shift >= {1'b0, den_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         // The quotient overflows 64 bits exactly when the upper half is not below den.
         ovf_in = num[127:64] >= den;
         rem_in = num[127:64];
         quo_in = num[63:0];
         den_in = den;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = rem_ge ? rem_diff[63:0] : rem_shift[63:0];
         quo_in = {quo_ff[62:0], rem_ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign status.busy = run_ff;
   assign status.done = done_ff;
   assign quo         = ovf_ff ? '1 : quo_ff;

endmodule

@@ src/inverse_variance_fusion_top.sv @@
// ----------------------------------------------------------------------------
// Inverse variance fusion top level
// A skipped non-final measurement leaves busy after the threshold check alone; a counted one
// goes on to the shared restoring divider (one weight reciprocal per item), then multiplies.
// A final item goes on to two divisions and a 32-step square root when weight was
// counted; with no counted weight it reports zeros at once. The result strobe is high for
// one cycle and the receiver cannot stall it.
// Synchronous active-high reset clears min_std, both accumulators and the sequencer.
// ----------------------------------------------------------------------------
module inverse_variance_fusion_top (
   input  logic        clock,
   input  logic        reset,
   // Input item channel.
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_mean_value,
   input  logic [31:0] req_std_value,
   input  logic        req_last_item,
   // Result channel.
   output logic        rsp_valid,
   output logic [31:0] rsp_fused_mean,
   output logic [31:0] rsp_fused_std,
   output logic        rsp_fused_valid,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ivf_pkg::*;

   // The sequencer walks one item through a single multiplier and the shared divider.
   // Non-final items end after the accumulate step, or after the check if skipped;
   // with weight counted, the final item continues with the fused mean division, the
   // variance division and the square root, then clears the accumulators.
   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_SQUARE,
      S_DIVW_GO,
      S_DIVW_WAIT,
      S_MUL_LO,
      S_MUL_HI,
      S_ADD_HI,
      S_CONTRIB,
      S_ACCUM,
      S_FIN,
      S_DIVM_GO,
      S_DIVM_WAIT,
      S_DIVV_GO,
      S_DIVV_WAIT,
      S_SQRT
   } state_type;

   localparam int SCNT_W = $clog2(SQRT_STEPS);
   localparam logic [63:0] CAP_NEG64 = {1'b1, 63'd0};
   localparam logic [63:0] CAP_POS64 = {1'b0, {63{1'b1}}};
   localparam logic [63:0] CAP_NEG32 = 64'(1) << 31;
   localparam logic [63:0] CAP_POS32 = (64'(1) << 31) - 64'(1);
   localparam logic [63:0] SQRT_BIT0 = 64'(1) << 62;

   state_type         state_ff, state_in;
   logic [31:0]       min_std_ff, min_std_in;
   logic [31:0]       std_ff, std_in;
   logic [31:0]       mag_ff, mag_in;
   logic              neg_ff, neg_in;
   logic              last_ff, last_in;
   logic [63:0]       mul_ff, mul_in;
   logic [63:0]       w_ff, w_in;
   logic [95:0]       prod_ff, prod_in;
   logic [63:0]       contrib_ff, contrib_in;
   logic [63:0]       wt_ff, wt_in;
   logic [63:0]       wmt_ff, wmt_in;
   logic [31:0]       fm_ff, fm_in;
   logic [63:0]       sx_ff, sx_in;
   logic [63:0]       sres_ff, sres_in;
   logic [63:0]       sbit_ff, sbit_in;
   logic [SCNT_W-1:0] scnt_ff, scnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_mean_ff, rsp_mean_in;
   logic [31:0]       rsp_std_ff, rsp_std_in;
   logic              rsp_fvalid_ff, rsp_fvalid_in;

   // Shared multiplier.
   logic [31:0]    mul_a, mul_b;
   logic [63:0]    mul_p;
   // Shared divider.
   logic           div_start;
   logic [127:0]   div_num;
   logic [63:0]    div_den;
   div_status_type div_status;
   logic [63:0]    div_q;

   // Datapath helpers.
   logic           csr_write;
   logic [63:0]    rlo;
   logic           rhi_nz;
   logic [63:0]    cap64;
   logic [63:0]    mag_sat;
   logic [64:0]    wt_sum;
   logic [64:0]    wmt_sum;
   logic           wm_neg;
   logic [63:0]    wm_mag;
   logic [63:0]    cap32;
   logic [63:0]    q_sat;
   logic [63:0]    sqrt_t;
   logic [63:0]    sx_next, sres_next;

   ivf_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .status (div_status),
      .quo    (div_q)
   );

   // Multiplier operands: std squared, then the two halves of mean times weight.
   always_comb begin
      unique case (state_ff)
         S_MUL_LO: begin
            mul_a = mag_ff;
            mul_b = w_ff[31:0];
         end
         S_MUL_HI: begin
            mul_a = mag_ff;
            mul_b = w_ff[63:32];
         end
         default: begin
            mul_a = std_ff;
            mul_b = std_ff;
         end
      endcase
   end
   assign mul_p = 64'(mul_a) * 64'(mul_b);

   // The fused mean divides |weighted sum| * 2^F by the weight sum.
   assign wm_neg = wmt_ff[63];
   assign wm_mag = wm_neg ? (64'd0 - wmt_ff) : wmt_ff;

   always_comb begin
      div_start = 1'b0;
      div_num   = NUM_WIDE;
      div_den   = wt_ff;
      unique case (state_ff)
         S_DIVW_GO: begin
            div_start = 1'b1;
            div_den   = mul_ff;
         end
         S_DIVM_GO: begin
            div_start = 1'b1;
            div_num   = 128'(wm_mag) << FRAC_BITS;
         end
         S_DIVV_GO: begin
            div_start = 1'b1;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // Contribution: drop F fraction bits, saturate the magnitude, apply sign.
   assign rlo     = prod_ff[64+FRAC_BITS-1:FRAC_BITS];
   assign rhi_nz  = |prod_ff[95:64+FRAC_BITS];
   assign cap64   = neg_ff ? CAP_NEG64 : CAP_POS64;
   assign mag_sat = (rhi_nz || (rlo > cap64)) ? cap64 : rlo;

   // Saturating accumulator sums.
   assign wt_sum  = {1'b0, wt_ff} + {1'b0, w_ff};
   assign wmt_sum = {wmt_ff[63], wmt_ff} + {contrib_ff[63], contrib_ff};

   // Fused mean clamp to the signed 32-bit range.
   assign cap32 = wm_neg ? CAP_NEG32 : CAP_POS32;
   assign q_sat = (div_q > cap32) ? cap32 : div_q;

   // One step of the digit-by-digit integer square root.
   assign sqrt_t = sres_ff + sbit_ff;
   always_comb begin
      if (sx_ff >= sqrt_t) begin
         sx_next   = sx_ff - sqrt_t;
         sres_next = (sres_ff >> 1) + sbit_ff;
      end else begin
         sx_next   = sx_ff;
         sres_next = sres_ff >> 1;
      end
   end

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      state_in      = state_ff;
      min_std_in    = min_std_ff;
      std_in        = std_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      last_in       = last_ff;
      mul_in        = mul_ff;
      w_in          = w_ff;
      prod_in       = prod_ff;
      contrib_in    = contrib_ff;
      wt_in         = wt_ff;
      wmt_in        = wmt_ff;
      fm_in         = fm_ff;
      sx_in         = sx_ff;
      sres_in       = sres_ff;
      sbit_in       = sbit_ff;
      scnt_in       = scnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_mean_in   = rsp_mean_ff;
      rsp_std_in    = rsp_std_ff;
      rsp_fvalid_in = rsp_fvalid_ff;

      if (csr_write && (csr_paddr[2] == CSR_IDX_MIN_STD)) begin
         min_std_in = csr_pwdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               std_in   = req_std_value;
               neg_in   = req_mean_value[31];
               mag_in   = req_mean_value[31] ? (32'd0 - req_mean_value) : req_mean_value;
               last_in  = req_last_item;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // Zero deviation is always skipped, whatever the threshold holds.
            if ((std_ff == 32'd0) || (std_ff <= min_std_ff)) begin
               state_in = last_ff ? S_FIN : S_IDLE;
            end else begin
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            mul_in   = mul_p;
            state_in = S_DIVW_GO;
         end
         S_DIVW_GO: begin
            state_in = S_DIVW_WAIT;
         end
         S_DIVW_WAIT: begin
            if (div_status.done) begin
               w_in     = div_q;
               state_in = S_MUL_LO;
            end
         end
         S_MUL_LO: begin
            mul_in   = mul_p;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            prod_in  = 96'(mul_ff);
            mul_in   = mul_p;
            state_in = S_ADD_HI;
         end
         S_ADD_HI: begin
            prod_in  = prod_ff + (96'(mul_ff) << 32);
            state_in = S_CONTRIB;
         end
         S_CONTRIB: begin
            contrib_in = neg_ff ? (64'd0 - mag_sat) : mag_sat;
            state_in   = S_ACCUM;
         end
         S_ACCUM: begin
            wt_in = wt_sum[64] ? '1 : wt_sum[63:0];
            if (wmt_sum[64] != wmt_sum[63]) begin
               wmt_in = wmt_sum[64] ? CAP_NEG64 : CAP_POS64;
            end else begin
               wmt_in = wmt_sum[63:0];
            end
            state_in = last_ff ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            if (wt_ff == 64'd0) begin
               // Nothing counted: report zeros with the valid flag low.
               rsp_valid_in  = 1'b1;
               rsp_mean_in   = 32'd0;
               rsp_std_in    = 32'd0;
               rsp_fvalid_in = 1'b0;
               wt_in         = 64'd0;
               wmt_in        = 64'd0;
               state_in      = S_IDLE;
            end else begin
               state_in = S_DIVM_GO;
            end
         end
         S_DIVM_GO: begin
            state_in = S_DIVM_WAIT;
         end
         S_DIVM_WAIT: begin
            if (div_status.done) begin
               fm_in    = wm_neg ? (32'd0 - q_sat[31:0]) : q_sat[31:0];
               state_in = S_DIVV_GO;
            end
         end
         S_DIVV_GO: begin
            state_in = S_DIVV_WAIT;
         end
         S_DIVV_WAIT: begin
            if (div_status.done) begin
               sx_in    = div_q;
               sres_in  = 64'd0;
               sbit_in  = SQRT_BIT0;
               scnt_in  = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            sx_in   = sx_next;
            sres_in = sres_next;
            sbit_in = sbit_ff >> 2;
            scnt_in = scnt_ff + SCNT_W'(1);
            if (scnt_ff == SCNT_W'(SQRT_STEPS - 1)) begin
               // The root of a 64-bit value always fits in 32 bits.
               rsp_valid_in  = 1'b1;
               rsp_mean_in   = fm_ff;
               rsp_std_in    = sres_next[31:0];
               rsp_fvalid_in = 1'b1;
               wt_in         = 64'd0;
               wmt_in        = 64'd0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         min_std_ff   <= 32'd0;
         wt_ff        <= 64'd0;
         wmt_ff       <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_std_ff   <= min_std_in;
         wt_ff        <= wt_in;
         wmt_ff       <= wmt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      std_ff        <= std_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      last_ff       <= last_in;
      mul_ff        <= mul_in;
      w_ff          <= w_in;
      prod_ff       <= prod_in;
      contrib_ff    <= contrib_in;
      fm_ff         <= fm_in;
      sx_ff         <= sx_in;
      sres_ff       <= sres_in;
      sbit_ff       <= sbit_in;
      scnt_ff       <= scnt_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_std_ff    <= rsp_std_in;
      rsp_fvalid_ff <= rsp_fvalid_in;
   end

   // The block takes a new item only from the idle state.
   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fused_mean  = rsp_mean_ff;
   assign rsp_fused_std   = rsp_std_ff;
   assign rsp_fused_valid = rsp_fvalid_ff;

   // Register read back; addresses beyond the list read as zero.
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_MIN_STD) ? min_std_ff : 32'd0;
   assign csr_pready = 1'b1;

endmodule

@@ src/ivf_checker.sv @@
// ----------------------------------------------------------------------------
// Inverse variance fusion checker
// Port-level assertions on the fusion block, bound to the top level.
// ----------------------------------------------------------------------------
`include "inverse_variance_fusion_top_macros.svh"

module ivf_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_fused_mean,
   input logic [31:0] rsp_fused_std,
   input logic        rsp_fused_valid
);

   // An accepted item always raises busy in the cycle after it is taken.
   `IVF_ASSERT_RST(a_accept_busy, clock, reset, (start && !busy) |=> busy, "accept did not raise busy")

   // A result is only delivered as the block returns to idle.
   `IVF_ASSERT_RST(a_rsp_idle, clock, reset, rsp_valid |-> !busy, "result while busy")

   // Two results never come in adjacent cycles.
   `IVF_ASSERT_RST(a_rsp_gap, clock, reset, rsp_valid |=> !rsp_valid, "back-to-back results")

   // An empty list reports zeros.
   `IVF_ASSERT_RST(a_empty_zero, clock, reset,
      (rsp_valid && !rsp_fused_valid) |-> ((rsp_fused_mean == 32'd0) && (rsp_fused_std == 32'd0)),
      "empty result not zero")

   // Reset leaves no result strobe behind.
   `IVF_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_valid, "result after reset")

endmodule

bind inverse_variance_fusion_top ivf_checker u_ivf_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_fused_mean  (rsp_fused_mean),
   .rsp_fused_std   (rsp_fused_std),
   .rsp_fused_valid (rsp_fused_valid)
);
